[sv/rqi_pkg.sv]
// Shared widths and register index codes for the ray against quad intersection block.
package rqi_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 48;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CORNER = 3'd0,
		CFG_EDGE_U = 3'd1,
		CFG_EDGE_V = 3'd2,
		CFG_NORMAL = 3'd3,
		CFG_COORD  = 3'd4,
		CFG_OFFSET = 3'd5
	} cfg_idx_t;

endpackage

[sv/rqi_if.sv]
// Ray and result channel interfaces with valid/ready handshake.
interface rqi_ray_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic signed [15:0] origin_z;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic signed [31:0] t_min;
	logic signed [31:0] t_max;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_min, t_max, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_min, t_max, output ready);
endinterface

interface rqi_res_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] hit_distance;
	logic        [16:0] coord_alpha;
	logic        [16:0] coord_beta;
	logic               front_face;

	modport source (output valid, hit, hit_distance, coord_alpha, coord_beta, front_face,
		input ready);
	modport sink (input valid, hit, hit_distance, coord_alpha, coord_beta, front_face,
		output ready);
endinterface

[sv/ray_quad_intersection.sv]
// Pipelined ray against parallelogram intersection test.
//
// Usage: the quad is loaded through the write port (cfg_wen, cfg_idx, cfg_data)
// while the block is idle: corner, edge u, edge v, unit normal, helper vector w
// (packed Q8.8 x/y/z in bits 15:0, 31:16, 47:32) and the Q16.16 plane offset.
// Rays arrive as transactions on the ray channel; each produces exactly one
// result transaction on the res channel carrying hit, t, alpha, beta and the
// front-face flag. On a miss every result field is zero.
// Throughput is one ray per cycle while res does not stall. On its way from
// acceptance to res a ray passes the plane dot products and operand preparation,
// then the pipelined restoring divider that forms t (one quotient bit per stage),
// and then the range test, hit point, cross products and planar coordinates.
// The pipeline moves as a whole: when the result register holds a transaction
// that the receiver does not take, every stage holds and ray.ready drops; no
// transaction is lost or repeated.
// Reset (arst_n low) clears all valid bits and the configuration registers.
module ray_quad_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [rqi_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [rqi_pkg::CfgDataW-1:0]  cfg_data,
	rqi_ray_if.sink                       ray,
	rqi_res_if.source                     res
);

	typedef struct packed {
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		logic signed [15:0] oz;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic signed [31:0] tmin;
		logic signed [31:0] tmax;
		logic               neg;
		logic               ovf;
		logic               dzero;
		logic               dneg;
	} side_t;

	localparam int unsigned NDiv = 32;

	// Configuration registers.
	logic [47:0]        corner_q, edge_u_q, edge_v_q, normal_q, coord_q;
	logic signed [31:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			edge_u_q <= '0;
			edge_v_q <= '0;
			normal_q <= '0;
			coord_q  <= '0;
			offset_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				rqi_pkg::CFG_CORNER: corner_q <= cfg_data;
				rqi_pkg::CFG_EDGE_U: edge_u_q <= cfg_data;
				rqi_pkg::CFG_EDGE_V: edge_v_q <= cfg_data;
				rqi_pkg::CFG_NORMAL: normal_q <= cfg_data;
				rqi_pkg::CFG_COORD:  coord_q  <= cfg_data;
				rqi_pkg::CFG_OFFSET: offset_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic signed [15:0] nx, ny, nz, qx, qy, qz, ux, uy, uz, vx, vy, vz, wx, wy, wz;
	assign nx = normal_q[15:0];  assign ny = normal_q[31:16]; assign nz = normal_q[47:32];
	assign qx = corner_q[15:0];  assign qy = corner_q[31:16]; assign qz = corner_q[47:32];
	assign ux = edge_u_q[15:0];  assign uy = edge_u_q[31:16]; assign uz = edge_u_q[47:32];
	assign vx = edge_v_q[15:0];  assign vy = edge_v_q[31:16]; assign vz = edge_v_q[47:32];
	assign wx = coord_q[15:0];   assign wy = coord_q[31:16];  assign wz = coord_q[47:32];

	function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
		if (x > 41'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -41'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	// The whole pipeline advances together unless the result is stalled.
	logic adv;
	logic out_valid_q;
	assign adv       = !out_valid_q || res.ready;
	assign ray.ready = adv;

	// Stage 1: the six plane dot product terms.
	logic               v_s1;
	side_t              sd_s1;
	logic signed [31:0] pdx_s1, pdy_s1, pdz_s1, pox_s1, poy_s1, poz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= ray.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1 <= '{ox: ray.origin_x, oy: ray.origin_y, oz: ray.origin_z,
				dx: ray.dir_x, dy: ray.dir_y, dz: ray.dir_z,
				tmin: ray.t_min, tmax: ray.t_max,
				neg: 1'b0, ovf: 1'b0, dzero: 1'b0, dneg: 1'b0};
			pdx_s1 <= nx * ray.dir_x;
			pdy_s1 <= ny * ray.dir_y;
			pdz_s1 <= nz * ray.dir_z;
			pox_s1 <= nx * ray.origin_x;
			poy_s1 <= ny * ray.origin_y;
			poz_s1 <= nz * ray.origin_z;
		end
	end

	// Stage 2: denominator n.d and numerator D - n.O.
	logic               v_s2;
	side_t              sd_s2;
	logic signed [33:0] den_s2;
	logic signed [34:0] num_s2;
	logic signed [33:0] no_sum;
	assign no_sum = 34'(pox_s1) + 34'(poy_s1) + 34'(poz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2  <= sd_s1;
			den_s2 <= 34'(pdx_s1) + 34'(pdy_s1) + 34'(pdz_s1);
			num_s2 <= 35'(offset_q) - 35'(no_sum);
		end
	end

	// Stage 3 (divider stage 0): magnitudes, signs and the overflow test.
	// The quotient reaches 2^32 exactly when the numerator's upper part is
	// at least the divisor; then t saturates and the divider result is ignored.
	logic [33:0] den_mag;
	logic [34:0] num_mag;
	logic [50:0] nshift;
	side_t       sd_pre;
	assign den_mag = den_s2[33] ? 34'(-den_s2) : 34'(den_s2);
	assign num_mag = num_s2[34] ? 35'(-num_s2) : 35'(num_s2);
	assign nshift  = {num_mag, 16'd0};

	always_comb begin
		sd_pre       = sd_s2;
		sd_pre.neg   = num_s2[34] ^ den_s2[33];
		sd_pre.dneg  = den_s2[33];
		sd_pre.dzero = (den_s2 == '0);
		sd_pre.ovf   = (34'(nshift[50:32]) >= den_mag);
	end

	logic        v_sd   [0:NDiv];
	side_t       sd_sd  [0:NDiv];
	logic [33:0] rem_sd [0:NDiv];
	logic [33:0] den_sd [0:NDiv];
	logic [31:0] nlo_sd [0:NDiv];
	logic [31:0] quo_sd [0:NDiv];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sd[0] <= 1'b0;
		else if (adv)
			v_sd[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_sd[0]  <= sd_pre;
			rem_sd[0] <= 34'(nshift[50:32]);
			den_sd[0] <= den_mag;
			nlo_sd[0] <= nshift[31:0];
			quo_sd[0] <= '0;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	for (genvar k = 1; k <= NDiv; k++) begin : g_div
		logic [34:0] trial;
		logic        ge;
		logic [31:0] quo_next;
		assign trial = {rem_sd[k-1], nlo_sd[k-1][NDiv-k]};
		assign ge    = (trial >= 35'(den_sd[k-1]));

		always_comb begin
			quo_next         = quo_sd[k-1];
			quo_next[NDiv-k] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sd[k] <= 1'b0;
			else if (adv)
				v_sd[k] <= v_sd[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sd_sd[k]  <= sd_sd[k-1];
				den_sd[k] <= den_sd[k-1];
				nlo_sd[k] <= nlo_sd[k-1];
				rem_sd[k] <= ge ? 34'(trial - 35'(den_sd[k-1])) : trial[33:0];
				quo_sd[k] <= quo_next;
			end
		end
	end

	// Stage 4: signed, saturated t and the range and parallel tests.
	side_t              sdq;
	logic [31:0]        qm;
	logic signed [31:0] t_val;
	assign sdq = sd_sd[NDiv];
	assign qm  = quo_sd[NDiv];

	always_comb begin
		if (sdq.ovf)
			t_val = sdq.neg ? 32'sh80000000 : 32'sh7fffffff;
		else if (sdq.neg)
			t_val = qm[31] ? 32'sh80000000 : -$signed(qm);
		else
			t_val = qm[31] ? 32'sh7fffffff : $signed(qm);
	end

	logic               v_s4, miss_s4, front_s4;
	side_t              sd_s4;
	logic signed [31:0] t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_sd[NDiv];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4    <= sdq;
			t_s4     <= t_val;
			front_s4 <= sdq.dneg;
			miss_s4  <= sdq.dzero || !(t_val > sdq.tmin && t_val < sdq.tmax);
		end
	end

	// Stage 5: t times direction, exact Q24.24.
	logic               v_s5, miss_s5, front_s5;
	side_t              sd_s5;
	logic signed [31:0] t_s5;
	logic signed [47:0] tdx_s5, tdy_s5, tdz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (adv)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5    <= sd_s4;
			t_s5     <= t_s4;
			miss_s5  <= miss_s4;
			front_s5 <= front_s4;
			tdx_s5   <= t_s4 * sd_s4.dx;
			tdy_s5   <= t_s4 * sd_s4.dy;
			tdz_s5   <= t_s4 * sd_s4.dz;
		end
	end

	// Stage 6: hit point relative to the corner, p = O + t*d - q, saturated.
	logic               v_s6, miss_s6, front_s6;
	logic signed [31:0] t_s6, px_s6, py_s6, pz_s6;
	logic signed [40:0] px_w, py_w, pz_w;
	assign px_w = 41'(sd_s5.ox) * 41'sd256 + 41'(tdx_s5 >>> 8) - 41'(qx) * 41'sd256;
	assign py_w = 41'(sd_s5.oy) * 41'sd256 + 41'(tdy_s5 >>> 8) - 41'(qy) * 41'sd256;
	assign pz_w = 41'(sd_s5.oz) * 41'sd256 + 41'(tdz_s5 >>> 8) - 41'(qz) * 41'sd256;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s6     <= t_s5;
			miss_s6  <= miss_s5;
			front_s6 <= front_s5;
			px_s6    <= sat32(px_w);
			py_s6    <= sat32(py_w);
			pz_s6    <= sat32(pz_w);
		end
	end

	// Stage 7: cross product terms of p with v and with u.
	logic               v_s7, miss_s7, front_s7;
	logic signed [31:0] t_s7;
	logic signed [47:0] vyz_s7, vzy_s7, vzx_s7, vxz_s7, vxy_s7, vyx_s7;
	logic signed [47:0] uyz_s7, uzy_s7, uzx_s7, uxz_s7, uxy_s7, uyx_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s7     <= t_s6;
			miss_s7  <= miss_s6;
			front_s7 <= front_s6;
			vyz_s7   <= py_s6 * vz;
			vzy_s7   <= pz_s6 * vy;
			vzx_s7   <= pz_s6 * vx;
			vxz_s7   <= px_s6 * vz;
			vxy_s7   <= px_s6 * vy;
			vyx_s7   <= py_s6 * vx;
			uyz_s7   <= py_s6 * uz;
			uzy_s7   <= pz_s6 * uy;
			uzx_s7   <= pz_s6 * ux;
			uxz_s7   <= px_s6 * uz;
			uxy_s7   <= px_s6 * uy;
			uyx_s7   <= py_s6 * ux;
		end
	end

	// Stage 8: cross products p x v and p x u, floored to Q16.16.
	logic               v_s8, miss_s8, front_s8;
	logic signed [31:0] t_s8;
	logic signed [40:0] cvx_s8, cvy_s8, cvz_s8, cux_s8, cuy_s8, cuz_s8;
	logic signed [48:0] cvx_w, cvy_w, cvz_w, cux_w, cuy_w, cuz_w;
	assign cvx_w = 49'(vyz_s7) - 49'(vzy_s7);
	assign cvy_w = 49'(vzx_s7) - 49'(vxz_s7);
	assign cvz_w = 49'(vxy_s7) - 49'(vyx_s7);
	assign cux_w = 49'(uyz_s7) - 49'(uzy_s7);
	assign cuy_w = 49'(uzx_s7) - 49'(uxz_s7);
	assign cuz_w = 49'(uxy_s7) - 49'(uyx_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (adv)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s8     <= t_s7;
			miss_s8  <= miss_s7;
			front_s8 <= front_s7;
			cvx_s8   <= 41'(cvx_w >>> 8);
			cvy_s8   <= 41'(cvy_w >>> 8);
			cvz_s8   <= 41'(cvz_w >>> 8);
			cux_s8   <= 41'(cux_w >>> 8);
			cuy_s8   <= 41'(cuy_w >>> 8);
			cuz_s8   <= 41'(cuz_w >>> 8);
		end
	end

	// Stage 9: products with the helper vector w.
	logic               v_s9, miss_s9, front_s9;
	logic signed [31:0] t_s9;
	logic signed [56:0] avx_s9, avy_s9, avz_s9, aux_s9, auy_s9, auz_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (adv)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s9     <= t_s8;
			miss_s9  <= miss_s8;
			front_s9 <= front_s8;
			avx_s9   <= wx * cvx_s8;
			avy_s9   <= wy * cvy_s8;
			avz_s9   <= wz * cvz_s8;
			aux_s9   <= wx * cux_s8;
			auy_s9   <= wy * cuy_s8;
			auz_s9   <= wz * cuz_s8;
		end
	end

	// Stage 10: alpha, beta, the unit square test and the result register.
	// Beta uses p x u, which is the negation of u x p.
	logic signed [59:0] asum, bsum;
	logic signed [51:0] alpha_w, beta_w;
	logic               in_square;
	assign asum      = 60'(avx_s9) + 60'(avy_s9) + 60'(avz_s9);
	assign bsum      = -(60'(aux_s9) + 60'(auy_s9) + 60'(auz_s9));
	assign alpha_w   = 52'(asum >>> 8);
	assign beta_w    = 52'(bsum >>> 8);
	assign in_square = !miss_s9 && alpha_w >= 0 && alpha_w <= 52'sd65536
		&& beta_w >= 0 && beta_w <= 52'sd65536;

	logic               hit_s10, front_s10;
	logic signed [31:0] t_s10;
	logic [16:0]        alpha_s10, beta_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s10   <= in_square;
			t_s10     <= in_square ? t_s9 : '0;
			alpha_s10 <= in_square ? alpha_w[16:0] : '0;
			beta_s10  <= in_square ? beta_w[16:0] : '0;
			front_s10 <= in_square && front_s9;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.hit          = hit_s10;
	assign res.hit_distance = t_s10;
	assign res.coord_alpha  = alpha_s10;
	assign res.coord_beta   = beta_s10;
	assign res.front_face   = front_s10;

endmodule
